[hw/rtl/mmac_pkg.sv]
// ----------------------------------------------------------------------------
// mmac_pkg: shared types and constants for the magnetometer calibration unit
// Widths, reset bounds, mapping constants, sequencer states and the
// request/response structs of the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package mmac_pkg;

  localparam int AXES     = 3;
  localparam int AXIS_W   = 2;
  localparam int SAMPLE_W = 16;
  localparam int DEN_W    = 16;
  localparam int QUOT_W   = 8;
  localparam int NUM_W    = DEN_W + QUOT_W;
  localparam int FLAG_W   = 3;

  localparam logic [AXIS_W-1:0] AXIS_FIRST = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_LAST  = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 16'sd666;
  localparam logic signed [SAMPLE_W-1:0] MAX_RESET = -16'sd666;
  localparam logic [QUOT_W-1:0]          MAP_SPAN  = 8'd200;
  localparam logic signed [SAMPLE_W-1:0] MAP_LOW   = -16'sd100;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_SETUP  = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_WRITE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/mmac_cfg_if.sv]
// ----------------------------------------------------------------------------
// mmac_cfg_if: configuration write channel
// Carries the enable register's write data with a valid/ready transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmac_cfg_if;
  logic valid;
  logic ready;
  logic mag_enable;

  modport source (output valid, output mag_enable, input ready);
  modport sink   (input valid, input mag_enable, output ready);
endinterface

`default_nettype wire

[hw/rtl/mmac_sample_if.sv]
// ----------------------------------------------------------------------------
// mmac_sample_if: magnetometer sample channel
// One three-axis signed sample per valid/ready transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmac_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  mag_x;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  mag_y;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  mag_z;

  modport source (output valid, output mag_x, output mag_y, output mag_z, input ready);
  modport sink   (input valid, input mag_x, input mag_y, input mag_z, output ready);
endinterface

`default_nettype wire

[hw/rtl/mmac_result_if.sv]
// ----------------------------------------------------------------------------
// mmac_result_if: calibrated result channel
// Three mapped axis values and the per-axis scaled flags per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmac_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  cal_x;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  cal_y;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  cal_z;
  logic [mmac_pkg::FLAG_W-1:0]           axes_scaled;

  modport source (output valid, output cal_x, output cal_y, output cal_z,
                  output axes_scaled, input ready);
  modport sink   (input valid, input cal_x, input cal_y, input cal_z,
                  input axes_scaled, output ready);
endinterface

`default_nettype wire

[hw/rtl/mmac_divider.sv]
// ----------------------------------------------------------------------------
// mmac_divider: iterative restoring divider
// One quotient bit per cycle, eight quotient bits per division. The quotient is
// known to fit in eight bits, so the divisor starts shifted left by seven.
// ----------------------------------------------------------------------------
`default_nettype none

module mmac_divider (
  input  logic               clk,
  input  logic               rst,
  input  mmac_pkg::div_req_t req,
  output mmac_pkg::div_rsp_t rsp
);

  localparam int SH_W = mmac_pkg::DEN_W + mmac_pkg::QUOT_W - 1;

  logic                          busy;
  logic                          done;
  logic [2:0]                    step;
  logic [mmac_pkg::NUM_W-1:0]    rem;
  logic [SH_W-1:0]               dsh;
  logic [mmac_pkg::QUOT_W-1:0]   quot;
  logic [mmac_pkg::NUM_W:0]      trial;
  logic                          ge;

  assign trial = {1'b0, rem} - {2'b00, dsh};
  assign ge    = ~trial[mmac_pkg::NUM_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == 3'd0);
      if (req.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && step == 3'd0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem  <= req.num;
      dsh  <= {req.den, 7'b0};
      step <= 3'd7;
    end else if (busy) begin
      if (ge) begin
        rem <= trial[mmac_pkg::NUM_W-1:0];
      end
      quot <= {quot[mmac_pkg::QUOT_W-2:0], ge};
      dsh  <= dsh >> 1;
      step <= step - 3'd1;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

`default_nettype wire

[hw/rtl/magnetometer_minmax_autocal_unit.sv]
// ----------------------------------------------------------------------------
// magnetometer_minmax_autocal_unit: min/max hard-iron auto-calibration
// Tracks a running min and max per axis and maps each sample onto
// -100..100 as (v-min)*200/(max-min)-100, one shared divider for all axes.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+----------------------------------------
//   cfg      | in  | valid/ready   | mag_enable (always ready)
//   sample   | in  | valid/ready   | mag_x, mag_y, mag_z (signed 16)
//   result   | out | valid/ready   | cal_x, cal_y, cal_z, axes_scaled
//
// Per axis, UPDATE widens min/max and SETUP forms the numerator; when the
// range is open the 8-step shared divider then runs in DIV, else the sample
// value passes through as is. WRITE then loads the result register; a disabled
// sample goes from IDLE straight to WRITE. sample.ready is high only in the
// idle state. The result register lets the unit return to idle while a result
// waits; a finished item then holds until the result is taken. Reset (rst,
// synchronous) sets min to 666, max to -666 and enable to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module magnetometer_minmax_autocal_unit (
  input  logic                 clk,
  input  logic                 rst,
  mmac_cfg_if.sink             cfg,
  mmac_sample_if.sink          sample,
  mmac_result_if.source        result
);

  localparam int SW = mmac_pkg::SAMPLE_W;

  mmac_pkg::state_t                    state;
  logic                                enable;
  logic [mmac_pkg::AXIS_W-1:0]         axis;
  logic signed [SW-1:0]                smp  [mmac_pkg::AXES];
  logic signed [SW-1:0]                mins [mmac_pkg::AXES];
  logic signed [SW-1:0]                maxs [mmac_pkg::AXES];
  logic signed [SW-1:0]                res  [mmac_pkg::AXES];
  logic [mmac_pkg::FLAG_W-1:0]         flags;

  logic                                out_valid;
  logic signed [SW-1:0]                out_cal [mmac_pkg::AXES];
  logic [mmac_pkg::FLAG_W-1:0]         out_flags;

  logic signed [SW-1:0]                cur_v;
  logic signed [SW-1:0]                cur_min;
  logic signed [SW-1:0]                cur_max;
  logic signed [SW:0]                  diff_full;
  logic signed [SW:0]                  span_full;
  logic [mmac_pkg::DEN_W-1:0]          den;
  logic                                collapsed;
  logic                                in_xfer;
  logic                                out_load;

  mmac_pkg::div_req_t                  div_req;
  mmac_pkg::div_rsp_t                  div_rsp;

  // Operands of the axis in work; by SETUP min/max are already widened in UPDATE.
  assign cur_v     = smp[axis];
  assign cur_min   = mins[axis];
  assign cur_max   = maxs[axis];
  assign diff_full = {cur_v[SW-1], cur_v} - {cur_min[SW-1], cur_min};
  assign span_full = {cur_max[SW-1], cur_max} - {cur_min[SW-1], cur_min};
  assign den       = span_full[mmac_pkg::DEN_W-1:0];
  assign collapsed = (den == '0);

  // Numerator (v-min)*200 fits 24 bits: the quotient never exceeds 200.
  assign div_req.start = (state == mmac_pkg::ST_SETUP) && !collapsed;
  assign div_req.num   = {8'b0, diff_full[SW-1:0]} * {16'b0, mmac_pkg::MAP_SPAN};
  assign div_req.den   = den;

  mmac_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_xfer  = sample.valid && sample.ready;
  assign out_load = (state == mmac_pkg::ST_WRITE) && (!out_valid || result.ready);

  assign cfg.ready    = 1'b1;
  assign sample.ready = (state == mmac_pkg::ST_IDLE);

  // Control: sequencer, enable register, calibration bounds, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mmac_pkg::ST_IDLE;
      enable    <= 1'b1;
      axis      <= mmac_pkg::AXIS_FIRST;
      out_valid <= 1'b0;
      for (int i = 0; i < mmac_pkg::AXES; i++) begin
        mins[i] <= mmac_pkg::MIN_RESET;
        maxs[i] <= mmac_pkg::MAX_RESET;
      end
    end else begin
      if (cfg.valid) begin
        enable <= cfg.mag_enable;
      end
      // Load a new result, or drop the old one once taken.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        mmac_pkg::ST_IDLE: begin
          if (in_xfer) begin
            axis  <= mmac_pkg::AXIS_FIRST;
            state <= enable ? mmac_pkg::ST_UPDATE : mmac_pkg::ST_WRITE;
          end
        end
        mmac_pkg::ST_UPDATE: begin
          // Widen the bounds by the sample.
          if (cur_v < cur_min) begin
            mins[axis] <= cur_v;
          end
          if (cur_v > cur_max) begin
            maxs[axis] <= cur_v;
          end
          state <= mmac_pkg::ST_SETUP;
        end
        mmac_pkg::ST_SETUP: begin
          if (!collapsed) begin
            state <= mmac_pkg::ST_DIV;
          end else if (axis == mmac_pkg::AXIS_LAST) begin
            state <= mmac_pkg::ST_WRITE;
          end else begin
            axis  <= axis + 2'd1;
            state <= mmac_pkg::ST_UPDATE;
          end
        end
        mmac_pkg::ST_DIV: begin
          if (div_rsp.done) begin
            if (axis == mmac_pkg::AXIS_LAST) begin
              state <= mmac_pkg::ST_WRITE;
            end else begin
              axis  <= axis + 2'd1;
              state <= mmac_pkg::ST_UPDATE;
            end
          end
        end
        mmac_pkg::ST_WRITE: begin
          // Hold until the result register is free.
          if (out_load) begin
            state <= mmac_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= mmac_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Payload: captured sample, per-axis results and flags, result register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      smp[0] <= sample.mag_x;
      smp[1] <= sample.mag_y;
      smp[2] <= sample.mag_z;
      flags  <= '0;
      // Disabled: zero results, bounds untouched.
      for (int i = 0; i < mmac_pkg::AXES; i++) begin
        res[i] <= '0;
      end
    end
    if (state == mmac_pkg::ST_SETUP && collapsed) begin
      res[axis] <= cur_v;
    end
    if (state == mmac_pkg::ST_DIV && div_rsp.done) begin
      res[axis]   <= $signed({8'b0, div_rsp.quot}) + mmac_pkg::MAP_LOW;
      flags[axis] <= 1'b1;
    end
    if (out_load) begin
      for (int i = 0; i < mmac_pkg::AXES; i++) begin
        out_cal[i] <= res[i];
      end
      out_flags <= flags;
    end
  end

  assign result.valid       = out_valid;
  assign result.cal_x       = out_cal[0];
  assign result.cal_y       = out_cal[1];
  assign result.cal_z       = out_cal[2];
  assign result.axes_scaled = out_flags;

endmodule

`default_nettype wire
